@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the ranger RTL.
// Needs a clk and an arst_n signal in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, off while reset is asserted
`define ECR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked property, also during reset
`define ECR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/ecr_pkg.sv @@
// Types and constants of the three-channel echo ranger.
// No dependencies; used by ecr_div and three_channel_echo_ranger_core.
package ecr_pkg;

	// channel count is fixed by the payload fields
	localparam int CHANNELS = 3;
	localparam int CH_W     = 2;

	// shared divider divisor width (covers 5844 and ticks_per_us)
	localparam int DEN_W    = 13;

	// distance scale: us * 1000 / 5844, saturated at 65535
	localparam int DIST_W       = 16;
	localparam int SCALE_NUM    = 1000;
	localparam int SCALE_DEN    = 5844;
	localparam int US_W         = 19;
	localparam int US_SAT       = ((65536 * SCALE_DEN) + SCALE_NUM - 1) / SCALE_NUM;
	localparam int PROD_W       = US_W + 10;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	// configuration registers
	localparam int TPU_W      = 10;
	localparam int TMO_W      = 32;
	localparam int PADDR_W    = 3;
	localparam logic REG_TPU  = 1'b0;
	localparam logic REG_TMO  = 1'b1;
	localparam logic [TPU_W-1:0] TPU_RESET = 10'd200;
	localparam logic [TMO_W-1:0] TMO_RESET = 32'd200000000;

	// input operation codes
	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	typedef struct packed {
		logic op;
		logic echo_front;
		logic echo_back;
		logic echo_top;
	} ecr_in_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance_front;
		logic [DIST_W-1:0] distance_back;
		logic [DIST_W-1:0] distance_top;
		logic              timed_out;
	} ecr_out_t;

	typedef enum logic [2:0] {
		ST_RUN,
		ST_US_GO,
		ST_US_WAIT,
		ST_MM_GO,
		ST_MM_WAIT,
		ST_FLUSH
	} ecr_state_t;

endpackage

@@ hw/rtl/three_channel_echo_ranger_core.sv @@
// A timeout result is staged at its tick, a completed one after two divisions per channel
// on the shared W-bit divider (W = max(COUNTER_BITS, 32)), the second skipped when the us
// value saturates; either result then waits in ST_FLUSH until the output register is free.
// Throughput: one tick per cycle while measuring; no input is taken during conversion or flush.
// Reset: registers to reset values (ticks_per_us 200, timeout 200000000), idle, no result.
// Depends on ecr_pkg, ecr_div and assert_macros.svh.
`include "assert_macros.svh"
module three_channel_echo_ranger_core #(
	parameter int COUNTER_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  ecr_pkg::ecr_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output ecr_pkg::ecr_out_t             out_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ecr_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import ecr_pkg::*;

	localparam int CW = (COUNTER_BITS > 32) ? COUNTER_BITS : 32;

	// config registers
	logic [TPU_W-1:0] tpu_q;
	logic [TMO_W-1:0] tmo_q;

	// measurement state
	logic [COUNTER_BITS-1:0] tick_q;
	logic [COUNTER_BITS-1:0] start_q [CHANNELS];
	logic [COUNTER_BITS-1:0] width_q [CHANNELS];
	logic [CHANNELS-1:0]     started_q;
	logic [CHANNELS-1:0]     done_q;
	logic                    measuring_q;

	// conversion and result staging
	ecr_state_t        state_q, state_d;
	logic [CH_W-1:0]   ch_q;
	logic [DIST_W-1:0] dist_q [CHANNELS];
	logic              to_q;
	logic              out_valid_q;
	ecr_out_t          out_data_q;

	// sequencer outputs
	logic div_start, div_mm, out_load;

	// tick evaluation
	logic                in_xfer;
	logic [CHANNELS-1:0] lvl;
	logic [CHANNELS-1:0] started_nx, done_nx;
	logic                tick_act, fin_ok, fin_to, last_ch;

	// divider hookup
	logic [CW-1:0]     div_dividend;
	logic [DEN_W-1:0]  div_divisor;
	logic              div_busy, div_done;
	logic [CW-1:0]     div_quo;
	logic              us_sat;
	logic [PROD_W-1:0] us_prod;
	logic [TPU_W-1:0]  tpu_eff;

	assign in_xfer  = in_valid && in_ready;
	assign lvl      = {in_data.echo_top, in_data.echo_back, in_data.echo_front};
	assign tick_act = (in_data.op == OP_TICK) && measuring_q;
	assign last_ch  = ch_q == CH_W'(CHANNELS - 1);

	// next channel flags for the current tick
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			started_nx[c] = started_q[c] || lvl[c];
			done_nx[c]    = done_q[c] || (started_q[c] && !lvl[c]);
		end
	end

	// completion wins over timeout on the same tick
	assign fin_ok = tick_act && (&done_nx);
	assign fin_to = tick_act && !(&done_nx) && (CW'(tick_q) > CW'(tmo_q));

	// APB config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q <= TPU_RESET;
			tmo_q <= TMO_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_TPU: tpu_q <= pwdata[TPU_W-1:0];
				REG_TMO: tmo_q <= pwdata[TMO_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_TPU: prdata = {{(32 - TPU_W){1'b0}}, tpu_q};
			REG_TMO: prdata = tmo_q;
			default: prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// measurement control: counter and per-channel flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			started_q   <= '0;
			done_q      <= '0;
			measuring_q <= 1'b0;
		end else if (in_xfer) begin
			if (in_data.op == OP_START) begin
				tick_q      <= '0;
				started_q   <= '0;
				done_q      <= '0;
				measuring_q <= 1'b1;
			end else if (measuring_q) begin
				started_q <= started_nx;
				done_q    <= done_nx;
				if (fin_ok || fin_to) begin
					measuring_q <= 1'b0;
				end else if (tick_q != '1) begin
					tick_q <= tick_q + 1'b1;
				end
			end
		end
	end

	// start ticks and captured widths
	always_ff @(posedge clk) begin
		if (in_xfer && tick_act) begin
			for (int c = 0; c < CHANNELS; c++) begin
				if (!started_q[c] && lvl[c]) begin
					start_q[c] <= tick_q;
				end
				if (started_q[c] && !done_q[c] && !lvl[c]) begin
					width_q[c] <= tick_q - start_q[c];
				end
			end
		end
	end

	// divider operands: width / ticks_per_us, then us * 1000 / 5844
	assign tpu_eff      = (tpu_q == '0) ? TPU_W'(1) : tpu_q;
	assign us_prod      = PROD_W'(div_quo[US_W-1:0]) * PROD_W'(SCALE_NUM);
	assign us_sat       = div_quo >= CW'(US_SAT);
	assign div_dividend = div_mm ? CW'(us_prod) : CW'(width_q[ch_q]);
	assign div_divisor  = div_mm ? DEN_W'(SCALE_DEN) : DEN_W'(tpu_eff);

	ecr_div #(
		.DW(CW),
		.VW(DEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer next state and controls
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		div_mm    = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_RUN: begin
				in_ready = 1'b1;
				if (in_valid && fin_ok) begin
					state_d = ST_US_GO;
				end else if (in_valid && fin_to) begin
					state_d = ST_FLUSH;
				end
			end
			ST_US_GO: begin
				div_start = 1'b1;
				state_d   = ST_US_WAIT;
			end
			ST_US_WAIT: begin
				if (div_done) begin
					if (!us_sat) begin
						state_d = ST_MM_GO;
					end else if (last_ch) begin
						state_d = ST_FLUSH;
					end else begin
						state_d = ST_US_GO;
					end
				end
			end
			ST_MM_GO: begin
				div_start = 1'b1;
				div_mm    = 1'b1;
				state_d   = ST_MM_WAIT;
			end
			ST_MM_WAIT: begin
				div_mm = 1'b1;
				if (div_done) begin
					state_d = last_ch ? ST_FLUSH : ST_US_GO;
				end
			end
			ST_FLUSH: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_RUN;
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

	// channel pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= '0;
		end else if (state_q == ST_RUN) begin
			ch_q <= '0;
		end else if (div_done && !last_ch &&
				((state_q == ST_US_WAIT && us_sat) || state_q == ST_MM_WAIT)) begin
			ch_q <= ch_q + 1'b1;
		end
	end

	// staged distances
	always_ff @(posedge clk) begin
		if (in_xfer && fin_to) begin
			for (int c = 0; c < CHANNELS; c++) begin
				dist_q[c] <= DIST_MAX;
			end
			to_q <= 1'b1;
		end else if (in_xfer && fin_ok) begin
			to_q <= 1'b0;
		end else if (div_done && state_q == ST_US_WAIT && us_sat) begin
			dist_q[ch_q] <= DIST_MAX;
		end else if (div_done && state_q == ST_MM_WAIT) begin
			dist_q[ch_q] <= div_quo[DIST_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q.distance_front <= dist_q[0];
			out_data_q.distance_back  <= dist_q[1];
			out_data_q.distance_top   <= dist_q[2];
			out_data_q.timed_out      <= to_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// checks
	`ECR_ASSERT(a_div_idle_on_start, div_start |-> !div_busy, "divider restarted while busy")
	`ECR_ASSERT(a_done_needs_start, (done_q & ~started_q) == '0, "channel done without start")
	`ECR_ASSERT(a_flush_holds, (state_q == ST_FLUSH && out_valid_q && !out_ready) |=> state_q == ST_FLUSH, "result dropped while output full")
	`ECR_ASSERT(a_timeout_sat, (out_valid_q && out_data_q.timed_out) |-> (out_data_q.distance_front == DIST_MAX && out_data_q.distance_back == DIST_MAX && out_data_q.distance_top == DIST_MAX), "timeout result not saturated")
	`ECR_ASSERT_ALWAYS(a_idle_divider, (state_q == ST_RUN || state_q == ST_FLUSH) |-> !div_busy, "divider busy outside conversion")

endmodule

@@ hw/rtl/ecr_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by all conversions.
// Depends on ecr_pkg.
module ecr_div #(
	parameter int DW = 32,
	parameter int VW = 13
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          busy,
	output logic          done,
	output logic [DW-1:0] quotient
);
	import ecr_pkg::*;

	localparam int CNT_W = $clog2(DW + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [VW-1:0]    rem_q;
	logic [VW-1:0]    den_q;
	logic [DW-1:0]    quo_q;
	logic [VW:0]      rem_sh;
	logic             ge;
	logic [VW:0]      rem_sub;

	// one restoring step
	assign rem_sh  = {rem_q, quo_q[DW-1]};
	assign ge      = rem_sh >= {1'b0, den_q};
	assign rem_sub = rem_sh - {1'b0, den_q};

	// control: bit counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(DW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign busy     = cnt_q != '0;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ tb/three_channel_echo_ranger_core_test.sv @@
`timescale 1ns / 1ps
// Testbench for three_channel_echo_ranger_core: directed table, random echo/noise bursts.
// Checks every result against a built-in model or checked row; uses ecr_pkg and the core.
module three_channel_echo_ranger_core_test;
	import ecr_pkg::*;

	// distance scale: floor(us * 1000 / 5844), saturating from this many us on
	localparam longint unsigned MM_NUM    = 1000;
	localparam longint unsigned MM_DEN    = 5844;
	localparam longint unsigned MM_SAT_US = 382993;
	localparam int PLAN_ROWS  = 27;
	localparam int RAND_ITEMS = 1850;

	typedef struct {
		bit          set_cfg;
		logic [31:0] tpu_word;
		logic [31:0] tmo_word;
		ecr_in_t     item;
		int unsigned reps;
		bit          typed;
		ecr_out_t    want;
	} plan_row_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	ecr_in_t             in_data  = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	ecr_out_t            out_data;
	logic                psel     = 1'b0;
	logic                penable  = 1'b0;
	logic                pwrite   = 1'b0;
	logic [PADDR_W-1:0]  paddr    = '0;
	logic [31:0]         pwdata   = '0;
	logic [31:0]         prdata;
	logic                pready;

	// model state and configuration
	logic [31:0] tick_cnt;
	logic [31:0] pulse_start [3];
	logic [31:0] pulse_ticks [3];
	bit          ch_started [3];
	bit          ch_done [3];
	bit          rng_armed;
	logic [9:0]  cfg_tpu = 10'd200;
	logic [31:0] cfg_tmo = 32'd200000000;

	ecr_out_t    pending_ranges [$];
	int unsigned fail_count = 0;
	int unsigned items_sent = 0;
	bit          idle_on = 1'b1;
	plan_row_t   plan [PLAN_ROWS];

	three_channel_echo_ranger_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	task automatic log_failure(string msg);
		fail_count++;
		if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
	endtask

	function automatic logic [15:0] width_to_distance(logic [31:0] w);
		longint unsigned div;
		longint unsigned us;
		div = (cfg_tpu == '0) ? 64'd1 : 64'(cfg_tpu);
		us = 64'(w) / div;
		if (us >= MM_SAT_US) return '1;
		return 16'((us * MM_NUM) / MM_DEN);
	endfunction

	// one item through the model; got is set when it ends a measurement
	task automatic ranger_predict(input ecr_in_t it, output bit got, output ecr_out_t res);
		logic [31:0] now;
		bit          lvl [3];
		bit          all_done;
		got = 1'b0;
		res = '0;
		if (it.op == OP_START) begin
			tick_cnt = '0;
			for (int c = 0; c < 3; c++) begin
				pulse_start[c] = '0;
				pulse_ticks[c] = '0;
				ch_started[c] = 1'b0;
				ch_done[c] = 1'b0;
			end
			rng_armed = 1'b1;
			return;
		end
		if (!rng_armed) return;
		now = tick_cnt;
		lvl = '{it.echo_front, it.echo_back, it.echo_top};
		all_done = 1'b1;
		for (int c = 0; c < 3; c++) begin
			if (!ch_started[c]) begin
				if (lvl[c]) begin
					ch_started[c] = 1'b1;
					pulse_start[c] = now;
				end
			end else if (!ch_done[c] && !lvl[c]) begin
				ch_done[c] = 1'b1;
				pulse_ticks[c] = now - pulse_start[c];
			end
			if (!ch_done[c]) all_done = 1'b0;
		end
		if (all_done) begin
			res.distance_front = width_to_distance(pulse_ticks[0]);
			res.distance_back  = width_to_distance(pulse_ticks[1]);
			res.distance_top   = width_to_distance(pulse_ticks[2]);
			res.timed_out      = 1'b0;
			rng_armed = 1'b0;
			got = 1'b1;
		end else if (now > cfg_tmo) begin
			res.distance_front = '1;
			res.distance_back  = '1;
			res.distance_top   = '1;
			res.timed_out      = 1'b1;
			rng_armed = 1'b0;
			got = 1'b1;
		end else if (now != '1) begin
			tick_cnt = now + 32'd1;
		end
	endtask

	// drive one input transfer, with random gaps when idling is on
	task automatic push_item(ecr_in_t it, bit use_typed = 1'b0, ecr_out_t typed_res = '0);
		bit       got;
		ecr_out_t res;
		while (idle_on && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		if (it.op == OP_START || rng_armed) items_sent++;
		ranger_predict(it, got, res);
		if (got) pending_ranges.push_back(use_typed ? typed_res : res);
	endtask

	function automatic ecr_in_t random_item(logic op);
		logic [3:0] bits;
		bits = 4'($urandom());
		bits[3] = op;
		return bits;
	endfunction

	// finish any armed measurement, then wait until the block has drained
	task automatic settle();
		ecr_in_t it;
		if (rng_armed) begin
			it.op = OP_TICK;
			it.echo_front = 1'b1;
			it.echo_back  = 1'b1;
			it.echo_top   = 1'b1;
			push_item(it);
		end
		if (rng_armed) begin
			it.op = OP_TICK;
			it.echo_front = 1'b0;
			it.echo_back  = 1'b0;
			it.echo_top   = 1'b0;
			push_item(it);
		end
		in_valid <= 1'b0;
		while (pending_ranges.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// APB write followed by a read-back of the same register
	task automatic write_reg(logic reg_sel, logic [31:0] val);
		logic [31:0] readback;
		readback = (reg_sel == REG_TPU) ? {22'd0, val[9:0]} : val;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {reg_sel, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (reg_sel == REG_TPU) cfg_tpu = val[9:0];
		else cfg_tmo = val;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== readback)
			log_failure($sformatf("register %0d read back %0h, expected %0h",
				reg_sel, prdata, readback));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// one well-formed measurement: a pulse per channel, a little noise
	task automatic echo_burst();
		int unsigned lead [3];
		int unsigned span [3];
		int unsigned last_t;
		ecr_in_t     it;
		last_t = 0;
		for (int c = 0; c < 3; c++) begin
			lead[c] = $urandom_range(0, 12);
			span[c] = $urandom_range(1, 24);
			if (lead[c] + span[c] > last_t) last_t = lead[c] + span[c];
		end
		last_t += $urandom_range(0, 4);
		push_item(random_item(OP_START));
		for (int unsigned t = 0; t <= last_t; t++) begin
			it.op = OP_TICK;
			it.echo_front = (t >= lead[0]) && (t < lead[0] + span[0]);
			it.echo_back  = (t >= lead[1]) && (t < lead[1] + span[1]);
			it.echo_top   = (t >= lead[2]) && (t < lead[2] + span[2]);
			if ($urandom_range(99) < 4) begin
				case ($urandom_range(2))
					0: it.echo_front = ~it.echo_front;
					1: it.echo_back  = ~it.echo_back;
					default: it.echo_top = ~it.echo_top;
				endcase
			end
			push_item(it);
			if (!rng_armed) break;
		end
		// stray ticks after the result are ignored by the block
		if ($urandom_range(2) == 0)
			repeat ($urandom_range(1, 3)) push_item(random_item(OP_TICK));
	endtask

	// random items with occasional restarts
	task automatic noise_burst();
		repeat ($urandom_range(5, 30))
			push_item(random_item(($urandom_range(7) == 0) ? OP_START : OP_TICK));
	endtask

	function automatic plan_row_t item_row(logic op, logic [2:0] lv, int unsigned reps);
		plan_row_t r;
		r = '{default: '0};
		r.item.op = op;
		r.item.echo_front = lv[2];
		r.item.echo_back  = lv[1];
		r.item.echo_top   = lv[0];
		r.reps = reps;
		return r;
	endfunction

	function automatic plan_row_t checked_row(plan_row_t r, logic [15:0] f, logic [15:0] b,
			logic [15:0] t, logic to);
		r.typed = 1'b1;
		r.want.distance_front = f;
		r.want.distance_back  = b;
		r.want.distance_top   = t;
		r.want.timed_out      = to;
		return r;
	endfunction

	function automatic plan_row_t cfg_row(logic [31:0] tpu, logic [31:0] tmo);
		plan_row_t r;
		r = '{default: '0};
		r.set_cfg = 1'b1;
		r.tpu_word = tpu;
		r.tmo_word = tmo;
		return r;
	endfunction

	// result side: check each transfer, stall at random while idling is on
	task automatic check_range(ecr_out_t got);
		ecr_out_t want;
		if (pending_ranges.size() == 0) begin
			log_failure($sformatf("unexpected result %0d/%0d/%0d timed_out=%0b",
				got.distance_front, got.distance_back, got.distance_top, got.timed_out));
			return;
		end
		want = pending_ranges.pop_front();
		if (got.distance_front !== want.distance_front
				|| got.distance_back !== want.distance_back
				|| got.distance_top !== want.distance_top
				|| got.timed_out !== want.timed_out)
			log_failure($sformatf({"result mismatch: expected %0d/%0d/%0d timed_out=%0b,",
				" got %0d/%0d/%0d timed_out=%0b"},
				want.distance_front, want.distance_back, want.distance_top, want.timed_out,
				got.distance_front, got.distance_back, got.distance_top, got.timed_out));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) check_range(out_data);
		out_ready <= !idle_on || ($urandom_range(99) >= 28);
	end

	// watchdog
	initial begin
		#30_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		logic [31:0] tpu_val;
		logic [31:0] tmo_val;
		int unsigned phase;

		plan = '{
			item_row(OP_TICK, 3'b111, 1),                               // tick while idle
			item_row(OP_START, 3'b000, 1),
			item_row(OP_TICK, 3'b111, 3),
			checked_row(item_row(OP_TICK, 3'b000, 1), 16'd0, 16'd0, 16'd0, 1'b0),
			item_row(OP_START, 3'b000, 1),
			item_row(OP_TICK, 3'b100, 2),
			item_row(OP_START, 3'b000, 1),                              // restart drops front
			item_row(OP_TICK, 3'b010, 1),
			item_row(OP_TICK, 3'b011, 4),
			item_row(OP_TICK, 3'b110, 1),
			item_row(OP_TICK, 3'b000, 1),
			cfg_row(32'd1, 32'd20),
			item_row(OP_START, 3'b000, 1),
			checked_row(item_row(OP_TICK, 3'b000, 22), 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1),
			item_row(OP_TICK, 3'b111, 1),
			cfg_row(32'd1, 32'd5),                                      // done and timeout together
			item_row(OP_START, 3'b000, 1),
			item_row(OP_TICK, 3'b111, 6),
			checked_row(item_row(OP_TICK, 3'b000, 1), 16'd1, 16'd1, 16'd1, 1'b0),
			cfg_row(32'd0, 32'hFFFF_FFFF),                              // zero divisor acts as 1
			item_row(OP_START, 3'b000, 1),
			item_row(OP_TICK, 3'b111, 12),
			item_row(OP_TICK, 3'b000, 1),
			cfg_row(32'hFFFF_FFFF, 32'd0),
			item_row(OP_START, 3'b000, 1),
			item_row(OP_TICK, 3'b111, 1),
			item_row(OP_TICK, 3'b000, 1)
		};

		tick_cnt = '0;
		rng_armed = 1'b0;
		for (int c = 0; c < 3; c++) begin
			pulse_start[c] = '0;
			pulse_ticks[c] = '0;
			ch_started[c] = 1'b0;
			ch_done[c] = 1'b0;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (plan[i]) begin
			if (plan[i].set_cfg) begin
				settle();
				write_reg(REG_TPU, plan[i].tpu_word);
				write_reg(REG_TMO, plan[i].tmo_word);
			end else begin
				idle_on = (plan[i].reps < 100);
				repeat (plan[i].reps) push_item(plan[i].item, plan[i].typed, plan[i].want);
			end
		end

		// random phases, each with its own settings
		items_sent = 0;
		phase = 0;
		while (items_sent < RAND_ITEMS) begin
			idle_on = (phase != 3);
			settle();
			case ($urandom_range(5))
				0: tpu_val = 32'd0;
				1: tpu_val = 32'd1;
				2: tpu_val = 32'd1023;
				3: tpu_val = 32'd1000;
				default: tpu_val = 32'($urandom_range(2, 8));
			endcase
			tpu_val |= $urandom() & 32'hFFFF_FC00;
			case ($urandom_range(3))
				0: tmo_val = 32'($urandom_range(0, 40));
				1: tmo_val = 32'($urandom_range(10, 40));
				2: tmo_val = 32'hFFFF_FFFF;
				default: tmo_val = $urandom();
			endcase
			write_reg(REG_TPU, tpu_val);
			write_reg(REG_TMO, tmo_val);
			repeat ($urandom_range(5, 10)) begin
				if ($urandom_range(99) < 85) echo_burst();
				else noise_burst();
			end
			phase++;
		end

		// drain
		in_valid <= 1'b0;
		while (pending_ranges.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
